>>> hw/rtl/lzw_stream_compressor_macros.svh
// Assertion macros used by the compressor top level.
`ifndef LZW_STREAM_COMPRESSOR_MACROS_SVH
`define LZW_STREAM_COMPRESSOR_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define LZW_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define LZW_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

>>> hw/rtl/lzw_pkg.sv
// Shared types and constants of the LZW stream compressor.
package lzw_pkg;
  localparam int CODE_W = 12;
  localparam int ACC_W = 19;
  localparam logic [CODE_W-1:0] FIRST_FREE_CODE = 12'd256;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] prefix;
    logic [7:0]        chr;
  } dict_entry_t;

  typedef struct packed {
    logic              vld;
    logic [CODE_W-1:0] code;
    logic [3:0]        width;
    logic              fin;
  } emit_req_t;

  typedef struct packed {
    logic ready;
    logic stopped;
  } emit_rsp_t;
endpackage

>>> hw/rtl/lzw_stream_compressor.sv
// LZW stream compressor top level: dictionary sequencer and configuration registers.
// A byte that hits on its first probe passes through accept, table read and compare;
// each collision adds one more read and compare of the dictionary RAM.
// A miss adds an emit state to hand the code over, which waits while the packer holds a whole byte.
// The packer moves each whole byte into its output register and drains one byte per cycle while out_tready is high.
// Reset is synchronous; after it and after every final byte the table clears all HASH_SLOTS slots.
module lzw_stream_compressor
  import lzw_pkg::*;
#(
  parameter int HASH_SLOTS = 5021
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [23:8] total_bytes
  output logic [1:0]  out_tuser,  // [0] out_valid, [1] overflow
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);
`include "lzw_stream_compressor_macros.svh"
  localparam int IW = $clog2(HASH_SLOTS);
  localparam logic [IW-1:0] LAST_SLOT = IW'(HASH_SLOTS - 1);
  localparam logic [IW:0] SLOTS = (IW+1)'(HASH_SLOTS);
  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_CMP = 3'd3,
                         S_EMIT = 3'd4, S_F1 = 3'd5, S_F2 = 3'd6, S_F3 = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        wsel_r;
  logic [15:0]       limit_r;
  logic [7:0]        ch_r, ch_nxt;
  logic              last_r, last_nxt;
  logic              first_r, first_nxt;
  logic [CODE_W-1:0] prefix_r, prefix_nxt;
  logic [CODE_W-1:0] next_code_r, next_code_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [IW-1:0]     k_r, k_nxt;
  logic [IW-1:0]     clr_r, clr_nxt;
  logic [2:0]        shift;
  logic [3:0]        width;
  logic [CODE_W-1:0] marker;
  logic [IW-1:0]     hash;
  logic [IW:0]       off_r, off_nxt, seed_off, probe;
  logic              we, re;
  logic [IW-1:0]     waddr;
  dict_entry_t       wdata, rdata;
  emit_req_t         req;
  emit_rsp_t         rsp;
  logic              accept;

  always_comb begin
    case (wsel_r)
      2'd0: shift = 3'd1;
      2'd1: shift = 3'd2;
      default: shift = 3'd4;
    endcase
  end
  assign width = 4'd8 + 4'(shift);
  assign marker = (CODE_W'(1) << width) - CODE_W'(1);
  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign hash = IW'((CODE_W'(in_tdata) << shift) ^ prefix_r);
  assign seed_off = (hash == '0) ? (IW+1)'(1) : SLOTS - {1'b0, hash};
  assign probe = ({1'b0, idx_r} >= off_r) ? {1'b0, idx_r} - off_r
                                          : {1'b0, idx_r} + SLOTS - off_r;

  always_comb begin
    state_nxt = state_r;
    ch_nxt = ch_r;
    last_nxt = last_r;
    first_nxt = first_r;
    prefix_nxt = prefix_r;
    next_code_nxt = next_code_r;
    idx_nxt = idx_r;
    off_nxt = off_r;
    k_nxt = k_r;
    clr_nxt = clr_r;
    we = 1'b0;
    re = 1'b0;
    waddr = idx_r;
    wdata = '0;
    req = '0;
    req.width = width;
    case (state_r)
      S_CLR: begin
        we = 1'b1;
        waddr = clr_r;
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + IW'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          ch_nxt = in_tdata;
          last_nxt = in_tlast;
          if (first_r) begin
            prefix_nxt = CODE_W'(in_tdata);
            first_nxt = 1'b0;
            state_nxt = in_tlast ? S_F1 : S_IDLE;
          end else if (rsp.stopped) begin
            state_nxt = in_tlast ? S_F1 : S_IDLE;
          end else begin
            idx_nxt = hash;
            off_nxt = seed_off;
            k_nxt = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        re = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!rdata.valid) begin
          if (next_code_r + CODE_W'(1) < marker) begin
            we = 1'b1;
            wdata = '{valid: 1'b1, code: next_code_r, prefix: prefix_r, chr: ch_r};
            next_code_nxt = next_code_r + CODE_W'(1);
          end
          state_nxt = S_EMIT;
        end else if (rdata.prefix == prefix_r && rdata.chr == ch_r) begin
          prefix_nxt = rdata.code;
          state_nxt = last_r ? S_F1 : S_IDLE;
        end else if (k_r == LAST_SLOT) begin
          state_nxt = S_EMIT;
        end else begin
          idx_nxt = IW'(probe);
          k_nxt = k_r + IW'(1);
          state_nxt = S_RD;
        end
      end
      S_EMIT: begin
        req.vld = 1'b1;
        req.code = prefix_r;
        if (rsp.ready) begin
          prefix_nxt = CODE_W'(ch_r);
          state_nxt = last_r ? S_F1 : S_IDLE;
        end
      end
      S_F1: begin
        req.vld = 1'b1;
        req.code = prefix_r;
        if (rsp.ready) begin
          state_nxt = S_F2;
        end
      end
      S_F2: begin
        req.vld = 1'b1;
        req.code = marker;
        if (rsp.ready) begin
          state_nxt = S_F3;
        end
      end
      S_F3: begin
        req.vld = 1'b1;
        req.code = CODE_W'(ch_r);
        req.fin = 1'b1;
        if (rsp.ready) begin
          first_nxt = 1'b1;
          prefix_nxt = '0;
          next_code_nxt = FIRST_FREE_CODE;
          clr_nxt = '0;
          state_nxt = S_CLR;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      first_r <= 1'b1;
      prefix_r <= '0;
      next_code_r <= FIRST_FREE_CODE;
      wsel_r <= 2'd2;
      limit_r <= 16'hFFFF;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      first_r <= first_nxt;
      prefix_r <= prefix_nxt;
      next_code_r <= next_code_nxt;
      if (cfg_we && cfg_addr == CFG_WIDTH) begin
        wsel_r <= cfg_wdata[1:0];
      end
      if (cfg_we && cfg_addr == CFG_LIMIT) begin
        limit_r <= cfg_wdata;
      end
    end
    ch_r <= ch_nxt;
    last_r <= last_nxt;
    idx_r <= idx_nxt;
    off_r <= off_nxt;
    k_r <= k_nxt;
  end

  lzw_dict_ram #(.DEPTH(HASH_SLOTS), .AW(IW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(idx_r), .rdata(rdata)
  );

  lzw_bit_packer u_pack (
    .clk(clk), .rst_n(rst_n), .byte_limit(limit_r), .req(req), .rsp(rsp),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  `LZW_ASSERT_NEXT(a_last_flushes, accept && in_tlast, state_r != S_IDLE, "final byte not flushed")
  `LZW_ASSERT_NOW(a_code_range, 1'b1, next_code_r <= 12'd4094, "next code out of range")
  `LZW_ASSERT_NOW(a_wr_source, we, state_r == S_CLR || state_r == S_CMP, "stray table write")
endmodule

>>> hw/rtl/lzw_dict_ram.sv
// Single-port-write, registered-read dictionary memory.
module lzw_dict_ram
  import lzw_pkg::*;
#(
  parameter int DEPTH = 5021,
  parameter int AW = 13
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  dict_entry_t    wdata,
  input  logic           re,
  input  logic [AW-1:0]  raddr,
  output dict_entry_t    rdata
);
  dict_entry_t mem [DEPTH];
  dict_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

>>> hw/rtl/lzw_bit_packer.sv
// Code packer: limit check, MSB-first bit accumulation and the output register.
module lzw_bit_packer
  import lzw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] byte_limit,
  input  emit_req_t   req,
  output emit_rsp_t   rsp,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic [15:0]      bytes_r, bytes_nxt;
  logic             stop_r, stop_nxt;
  logic             fin_r, fin_nxt;
  logic             stat_r, stat_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       obyte_r, obyte_nxt;
  logic             oflag_r, oflag_nxt;
  logic             oovf_r, oovf_nxt;
  logic             olast_r, olast_nxt;
  logic [15:0]      ototal_r, ototal_nxt;
  logic             out_free, ready;
  logic [4:0]       cnt_m8;
  logic [ACC_W-1:0] kept, cmask;

  assign out_free = !ovalid_r || out_tready;
  assign ready = (cnt_r < 5'd8) && !stat_r && !fin_r;
  assign rsp.ready = ready;
  assign rsp.stopped = stop_r;
  assign cnt_m8 = cnt_r - 5'd8;
  assign kept = acc_r & ((ACC_W'(1) << cnt_r) - ACC_W'(1));
  assign cmask = (ACC_W'(1) << req.width) - ACC_W'(1);

  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    bytes_nxt = bytes_r;
    stop_nxt = stop_r;
    fin_nxt = fin_r;
    stat_nxt = stat_r;
    ovalid_nxt = ovalid_r;
    obyte_nxt = obyte_r;
    oflag_nxt = oflag_r;
    oovf_nxt = oovf_r;
    olast_nxt = olast_r;
    ototal_nxt = ototal_r;
    if (out_free) begin
      ovalid_nxt = 1'b0;
    end
    if (out_free && cnt_r >= 5'd8) begin
      ovalid_nxt = 1'b1;
      obyte_nxt = 8'(acc_r >> cnt_m8);
      oflag_nxt = 1'b1;
      oovf_nxt = 1'b0;
      cnt_nxt = cnt_m8;
      bytes_nxt = bytes_r + 16'd1;
      olast_nxt = fin_r && (cnt_m8 < 5'd8);
      ototal_nxt = olast_nxt ? bytes_nxt : 16'd0;
      if (olast_nxt) begin
        cnt_nxt = '0;
        bytes_nxt = '0;
        stop_nxt = 1'b0;
        fin_nxt = 1'b0;
      end
    end else if (out_free && stat_r) begin
      ovalid_nxt = 1'b1;
      obyte_nxt = '0;
      oflag_nxt = 1'b0;
      oovf_nxt = stop_r;
      olast_nxt = 1'b1;
      ototal_nxt = bytes_r;
      cnt_nxt = '0;
      bytes_nxt = '0;
      stop_nxt = 1'b0;
      stat_nxt = 1'b0;
    end else if (ready && req.vld) begin
      if (!stop_r) begin
        if ({1'b0, bytes_r} + 17'd1 < {1'b0, byte_limit}) begin
          acc_nxt = (kept << req.width) | (ACC_W'(req.code) & cmask);
          cnt_nxt = cnt_r + 5'(req.width);
        end else begin
          stop_nxt = 1'b1;
        end
      end
      if (req.fin) begin
        if (stop_nxt) begin
          stat_nxt = 1'b1;
        end else begin
          fin_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      bytes_r <= '0;
      stop_r <= 1'b0;
      fin_r <= 1'b0;
      stat_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      bytes_r <= bytes_nxt;
      stop_r <= stop_nxt;
      fin_r <= fin_nxt;
      stat_r <= stat_nxt;
      ovalid_r <= ovalid_nxt;
    end
    acc_r <= acc_nxt;
    obyte_r <= obyte_nxt;
    oflag_r <= oflag_nxt;
    oovf_r <= oovf_nxt;
    olast_r <= olast_nxt;
    ototal_r <= ototal_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {ototal_r, obyte_r};
  assign out_tuser = {oovf_r, oflag_r};
  assign out_tlast = olast_r;
endmodule

>>> sim/testbench.sv
// Self-checking testbench for the LZW stream compressor with a built-in predictor.
module testbench;
  import lzw_pkg::*;

  localparam int SLOTS = 5021;
  localparam int IDLE_LIMIT = 200000;
  localparam int CFG_WIDTH = 0;
  localparam int CFG_LIMIT = 1;

  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    logic        last;
    logic        ovf;
    logic [15:0] total;
  } out_item_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } stim_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [7:0] in_tdata = 0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [23:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_we = 0;
  logic cfg_addr = 0;
  logic [15:0] cfg_wdata = 0;

  always #4 clk = ~clk;

  lzw_stream_compressor #(.HASH_SLOTS(SLOTS)) u_dut (.*);

  // Predictor state.
  logic [32:0] dict [SLOTS];
  logic [11:0] pfx;
  logic [11:0] nxt;
  logic [31:0] acc;
  int unsigned nbits;
  logic [15:0] nbytes;
  bit first_byte;
  bit halted;
  logic [1:0] wsel;
  logic [15:0] limit;

  out_item_t expected_bytes[$];
  int errors = 0;
  bit no_idle = 0;
  int idle_cycles = 0;

  task automatic report(string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic clear_block();
    foreach (dict[i]) dict[i] = '0;
    pfx = 0; nxt = 256; acc = 0; nbits = 0; nbytes = 0;
    first_byte = 1; halted = 0;
  endtask

  task automatic pack_code(logic [11:0] code, int unsigned w, inout int n);
    out_item_t r;
    if (halted) return;
    if (!(32'(nbytes) + 1 < 32'(limit))) begin
      halted = 1;
      return;
    end
    acc = (acc << w) | (32'(code) & ((32'd1 << w) - 1));
    nbits += w;
    while (nbits >= 8) begin
      r = '{data: 8'(acc >> (nbits - 8)), valid: 1, last: 0, ovf: 0, total: 0};
      expected_bytes.push_back(r);
      n++;
      nbits -= 8;
      nbytes++;
    end
    acc &= (32'd1 << nbits) - 1;
  endtask

  task automatic compress_byte(logic [7:0] ch, logic fin);
    int unsigned sh, w, mark, idx, off, k;
    bit hit, empty;
    int n;
    out_item_t r;
    sh = (wsel == 0) ? 1 : (wsel == 1) ? 2 : 4;
    w = 8 + sh;
    mark = (1 << w) - 1;
    n = 0;
    if (first_byte) begin
      pfx = 12'(ch);
      first_byte = 0;
    end else if (!halted) begin
      idx = ((32'(ch) << sh) ^ 32'(pfx)) % SLOTS;
      off = idx ? SLOTS - idx : 1;
      hit = 0; empty = 0;
      for (k = 0; k < SLOTS; k++) begin
        if (!dict[idx][32]) begin
          empty = 1;
          break;
        end
        if (dict[idx][19:8] == pfx && dict[idx][7:0] == ch) begin
          pfx = dict[idx][31:20];
          hit = 1;
          break;
        end
        idx = (idx >= off) ? idx - off : idx + SLOTS - off;
      end
      if (!hit) begin
        if (empty && 32'(nxt) + 1 < mark) begin
          dict[idx] = {1'b1, nxt, pfx, ch};
          nxt++;
        end
        pack_code(pfx, w, n);
        pfx = 12'(ch);
      end
    end
    if (fin) begin
      pack_code(pfx, w, n);
      pack_code(12'(mark), w, n);
      pack_code(12'(ch), w, n);
      if (halted || n == 0) begin
        r = '{data: 0, valid: 0, last: 1, ovf: halted, total: nbytes};
        expected_bytes.push_back(r);
      end else begin
        r = expected_bytes.pop_back();
        r.last = 1;
        r.total = nbytes;
        expected_bytes.push_back(r);
      end
      clear_block();
    end
  endtask

  task automatic write_reg(int idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_addr <= idx[0];
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_WIDTH) wsel = val[1:0];
    else limit = val;
  endtask

  task automatic wait_idle();
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_byte(logic [7:0] b, logic fin);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= b;
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    compress_byte(b, fin);
  endtask

  // Result checking and receiver stalls.
  always @(posedge clk) begin
    out_item_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{data: out_tdata[7:0], valid: out_tuser[0], last: out_tlast,
              ovf: out_tuser[1], total: out_tdata[23:8]};
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected transfer %h", got));
      end else begin
        exp = expected_bytes.pop_front();
        if (got.data !== exp.data) report($sformatf("byte %h exp %h", got.data, exp.data));
        if (got.valid !== exp.valid) report("out_valid differs");
        if (got.last !== exp.last) report("tlast differs");
        if (got.ovf !== exp.ovf) report("overflow differs");
        if (got.total !== exp.total)
          report($sformatf("total %0d exp %0d", got.total, exp.total));
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (no_idle) begin
      out_tready <= 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 0;
    end else if ($urandom_range(0, 6) == 0) begin
      stall_left <= $urandom_range(1, 19);
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  stim_t directed[] = '{
    '{8'h00, 1}, '{8'hFF, 1},
    '{8'h41, 0}, '{8'h41, 0}, '{8'h41, 0}, '{8'h41, 0}, '{8'h42, 1},
    '{8'h00, 0}, '{8'hFF, 0}, '{8'h00, 0}, '{8'hFF, 0}, '{8'h00, 0}, '{8'hFF, 1},
    '{8'h55, 0}, '{8'hAA, 0}, '{8'h55, 0}, '{8'hAA, 0}, '{8'h55, 0}, '{8'hAA, 1}
  };

  initial begin
    int n, blen, alpha;
    logic [1:0] wsels[4] = '{2'd0, 2'd1, 2'd2, 2'd3};
    clear_block();
    wsel = 2; limit = 16'hFFFF;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (wsels[i]) begin
      write_reg(CFG_WIDTH, 16'(wsels[i]));
      foreach (directed[j]) send_byte(directed[j].data, directed[j].last);
      in_tvalid <= 0;
      wait_idle();
    end
    write_reg(CFG_LIMIT, 16'd1);
    send_byte(8'h12, 1);
    send_byte(8'h34, 0);
    send_byte(8'h35, 0);
    send_byte(8'h36, 1);
    in_tvalid <= 0;
    wait_idle();
    write_reg(CFG_LIMIT, 16'd3);
    for (int i = 0; i < 10; i++) send_byte(8'(i * 37), i == 9);
    in_tvalid <= 0;
    wait_idle();
    n = 0;
    while (n < 110) begin
      write_reg(CFG_WIDTH, 16'($urandom_range(0, 3)));
      write_reg(CFG_LIMIT, ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 12))
                                                        : 16'hFFFF);
      if (n > 80) no_idle = 1;
      blen = $urandom_range(1, 30);
      alpha = $urandom_range(0, 2);
      for (int i = 0; i < blen; i++) begin
        logic [7:0] b;
        b = (alpha == 0) ? 8'($urandom) : 8'($urandom_range(0, alpha * 2)) ^ 8'hC3;
        send_byte(b, i == blen - 1);
        n++;
      end
      in_tvalid <= 0;
      wait_idle();
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
